// File: src/spk_pkg.sv
// spk_pkg: shared types, constants and rotate helpers for the speck128/128 core
// no dependencies

package spk_pkg;

  localparam int unsigned WORD_W          = 64;
  localparam int unsigned ROUND_COUNT_DEF = 32;
  localparam int unsigned ROR_AMT         = 8;
  localparam int unsigned ROL_AMT         = 3;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_SECOND = 1'd1;

  typedef struct packed {
    logic [WORD_W-1:0] plain_y;
    logic [WORD_W-1:0] plain_x;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] cipher_y;
    logic [WORD_W-1:0] cipher_x;
  } out_word_t;

  // block and key schedule state carried along the pipeline
  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] k;
    logic [WORD_W-1:0] l;
  } round_state_t;

  function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
    ror8 = {v[ROR_AMT-1:0], v[WORD_W-1:ROR_AMT]};
  endfunction

  function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
    rol3 = {v[WORD_W-ROL_AMT-1:0], v[WORD_W-1:WORD_W-ROL_AMT]};
  endfunction

endpackage

// File: src/spk_round_stage.sv
// spk_round_stage: one registered speck round plus one key schedule step
// depends on spk_pkg

module spk_round_stage #(
  parameter int unsigned ROUND_IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 valid_i,
  input  spk_pkg::round_state_t state_i,
  output logic                 valid_o,
  output spk_pkg::round_state_t state_o
);

  localparam logic [spk_pkg::WORD_W-1:0] RoundConst = spk_pkg::WORD_W'(ROUND_IDX);

  logic                  valid_q;
  spk_pkg::round_state_t state_d, state_q;

  always_comb begin
    state_d.x = (spk_pkg::ror8(state_i.x) + state_i.y) ^ state_i.k;
    state_d.y = spk_pkg::rol3(state_i.y) ^ state_d.x;
    state_d.l = (spk_pkg::ror8(state_i.l) + state_i.k) ^ RoundConst;
    state_d.k = spk_pkg::rol3(state_i.k) ^ state_d.l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// File: src/speck128_128_encrypt_core.sv
// speck128_128_encrypt_core: fully unrolled speck128/128 encryption pipeline
// depends on spk_pkg and spk_round_stage
// an accepted input word passes through every round register in turn before output valid
// throughput: one word per cycle while the output is not stalled, one round register stage per round
// the whole pipeline holds while an output word waits under stall
// reset clears valid bits and sets both key words to zero

module speck128_128_encrypt_core #(
  parameter int unsigned ROUND_COUNT = spk_pkg::ROUND_COUNT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spk_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [spk_pkg::WORD_W-1:0]      cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  spk_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output spk_pkg::out_word_t              out_word_o
);

  logic [spk_pkg::WORD_W-1:0] key_first_q, key_second_q;
  logic                       adv;
  logic [ROUND_COUNT:0]       valid;
  spk_pkg::round_state_t      state [ROUND_COUNT+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_first_q  <= '0;
      key_second_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        spk_pkg::REG_KEY_FIRST:  key_first_q  <= cfg_data_i;
        spk_pkg::REG_KEY_SECOND: key_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv = !(valid[ROUND_COUNT] && out_stall_i);

  assign valid[0]   = in_valid_i;
  assign state[0].x = in_word_i.plain_x;
  assign state[0].y = in_word_i.plain_y;
  assign state[0].k = key_first_q;
  assign state[0].l = key_second_q;

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    spk_round_stage #(
      .ROUND_IDX(r)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid[r]),
      .state_i (state[r]),
      .valid_o (valid[r+1]),
      .state_o (state[r+1])
    );
  end

  assign in_stall_o          = !adv;
  assign out_valid_o         = valid[ROUND_COUNT];
  assign out_word_o.cipher_x = state[ROUND_COUNT].x;
  assign out_word_o.cipher_y = state[ROUND_COUNT].y;

  // accepted word lands in the first round register
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid[1])
    else $error("accepted word did not enter pipeline");

  // a held output word freezes the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while output held");

  // nothing moves inside the pipeline while stalled
  a_stall_freezes_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(valid[ROUND_COUNT:1]))
    else $error("pipeline valid bits moved during stall");

  // words in flight are conserved across a stalled cycle
  a_stall_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $countones(valid[ROUND_COUNT:1]) == $past($countones(valid[ROUND_COUNT:1])))
    else $error("word count changed during stall");

endmodule

// File: tb/testbench.sv
// testbench for speck128_128_encrypt_core: directed table plus random words
// depends on spk_pkg and the core; checks every output word against a built-in speck predictor or a published vector

`timescale 1ns / 100ps

module testbench;

  localparam int unsigned ROUNDS = spk_pkg::ROUND_COUNT_DEF;
  localparam int unsigned DRAIN_CYCLES = ROUNDS + 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 90;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned WORDS_PER_PHASE = 56;
  localparam logic [spk_pkg::WORD_W-1:0] ONES = {spk_pkg::WORD_W{1'b1}};
  localparam logic [spk_pkg::WORD_W-1:0] MSB = {1'b1, {(spk_pkg::WORD_W-1){1'b0}}};
  localparam logic [spk_pkg::WORD_W-1:0] ALT_A = {(spk_pkg::WORD_W/2){2'b10}};
  localparam logic [spk_pkg::WORD_W-1:0] ALT_5 = {(spk_pkg::WORD_W/2){2'b01}};
  localparam logic [spk_pkg::WORD_W-1:0] TV_K = 64'h0706050403020100;
  localparam logic [spk_pkg::WORD_W-1:0] TV_L = 64'h0f0e0d0c0b0a0908;

  typedef struct packed {
    logic [spk_pkg::WORD_W-1:0] key_k;
    logic [spk_pkg::WORD_W-1:0] key_l;
    logic [spk_pkg::WORD_W-1:0] y;
    logic [spk_pkg::WORD_W-1:0] x;
    logic                       known;
    logic [spk_pkg::WORD_W-1:0] cy;
    logic [spk_pkg::WORD_W-1:0] cx;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 12;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{64'd0, 64'd0, 64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{64'd0, 64'd0, ONES,  ONES,  1'b0, 64'd0, 64'd0},
    '{64'd0, 64'd0, 64'd0, ONES,  1'b0, 64'd0, 64'd0},
    '{64'd0, 64'd0, ONES,  64'd0, 1'b0, 64'd0, 64'd0},
    '{64'd0, 64'd0, MSB,   64'd1, 1'b0, 64'd0, 64'd0},
    '{64'd0, 64'd0, 64'd1, MSB,   1'b0, 64'd0, 64'd0},
    '{ONES,  ONES,  64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{ONES,  ONES,  ONES,  ONES,  1'b0, 64'd0, 64'd0},
    // published speck128/128 vector
    '{TV_K, TV_L, 64'h7469206564616d20, 64'h6c61766975716520,
      1'b1, 64'h7860fedf5c570d18, 64'ha65d985179783265},
    '{TV_K,  TV_L,  64'd0, 64'd0, 1'b0, 64'd0, 64'd0},
    '{64'd0, ONES,  ALT_A, ALT_5, 1'b0, 64'd0, 64'd0},
    '{ONES,  64'd0, ALT_5, ALT_A, 1'b0, 64'd0, 64'd0}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [spk_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic [spk_pkg::WORD_W-1:0]        cfg_data_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  spk_pkg::in_word_t                 in_word_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  spk_pkg::out_word_t                out_word_o;

  logic [spk_pkg::WORD_W-1:0] cur_k;
  logic [spk_pkg::WORD_W-1:0] cur_l;
  spk_pkg::out_word_t         cipher_q [$];
  spk_pkg::out_word_t         oldest;
  int unsigned                fail_cnt = 0;
  int unsigned                quiet_cnt = 0;
  int unsigned                gap_pct = 0;
  int unsigned                stall_pct = 0;
  int unsigned                hold_left = 0;
  logic                       hold_req;

  speck128_128_encrypt_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic spk_pkg::out_word_t speck_encrypt(
    input logic [spk_pkg::WORD_W-1:0] k0,
    input logic [spk_pkg::WORD_W-1:0] l0,
    input spk_pkg::in_word_t w);
    logic [spk_pkg::WORD_W-1:0] x;
    logic [spk_pkg::WORD_W-1:0] y;
    logic [spk_pkg::WORD_W-1:0] k;
    logic [spk_pkg::WORD_W-1:0] l;
    spk_pkg::out_word_t r;
    x = w.plain_x;
    y = w.plain_y;
    k = k0;
    l = l0;
    for (int i = 0; i < ROUNDS; i++) begin
      x = ({x[7:0], x[spk_pkg::WORD_W-1:8]} + y) ^ k;
      y = {y[spk_pkg::WORD_W-4:0], y[spk_pkg::WORD_W-1:spk_pkg::WORD_W-3]} ^ x;
      l = ({l[7:0], l[spk_pkg::WORD_W-1:8]} + k) ^ spk_pkg::WORD_W'(i);
      k = {k[spk_pkg::WORD_W-4:0], k[spk_pkg::WORD_W-1:spk_pkg::WORD_W-3]} ^ l;
    end
    r.cipher_y = y;
    r.cipher_x = x;
    return r;
  endfunction

  function automatic logic [spk_pkg::WORD_W-1:0] pick_value();
    logic [spk_pkg::WORD_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: v = ONES;
      2: v = MSB >> $urandom_range(spk_pkg::WORD_W-1);
      3: v = ~(MSB >> $urandom_range(spk_pkg::WORD_W-1));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  task automatic send_word(input spk_pkg::in_word_t w, input spk_pkg::out_word_t cw);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    cipher_q.push_back(cw);
  endtask

  // keys change only with the pipeline empty
  task automatic load_key(input logic [spk_pkg::WORD_W-1:0] k,
                          input logic [spk_pkg::WORD_W-1:0] l);
    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= spk_pkg::REG_KEY_FIRST;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_index_i <= spk_pkg::REG_KEY_SECOND;
    cfg_data_i <= l;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_k = k;
    cur_l = l;
  endtask

  // receiver side, with a long hold on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    out_stall_i <= hold_req || hold_left != 0 ||
                   (stall_pct != 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("output word with nothing expected: y %h x %h",
                   out_word_o.cipher_y, out_word_o.cipher_x);
        end
      end else begin
        oldest = cipher_q.pop_front();
        if (out_word_o.cipher_y !== oldest.cipher_y ||
            out_word_o.cipher_x !== oldest.cipher_x) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("cipher mismatch: y exp %h got %h, x exp %h got %h",
                     oldest.cipher_y, out_word_o.cipher_y,
                     oldest.cipher_x, out_word_o.cipher_x);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cnt <= 0;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
      if (quiet_cnt >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    spk_pkg::in_word_t w;
    spk_pkg::out_word_t cw;
    dir_row_t row;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= spk_pkg::REG_KEY_FIRST;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_word_i <= '0;
    hold_req <= 1'b0;
    cur_k = '0;
    cur_l = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[r];
      if (row.key_k !== cur_k || row.key_l !== cur_l) begin
        load_key(row.key_k, row.key_l);
      end
      w.plain_y = row.y;
      w.plain_x = row.x;
      if (row.known) begin
        cw.cipher_y = row.cy;
        cw.cipher_x = row.cx;
      end else begin
        cw = speck_encrypt(cur_k, cur_l, w);
      end
      send_word(w, cw);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: load_key(ONES, ONES);
        2: load_key('0, ONES);
        3: load_key(ONES, '0);
        default: load_key(pick_value(), pick_value());
      endcase
      case (p % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 58; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 58; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      if (p == 4) begin
        // long output hold so the pipeline fills and backs up
        hold_req <= 1'b1;
        @(posedge clk_i);
        hold_req <= 1'b0;
      end
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w.plain_y = pick_value();
        w.plain_x = pick_value();
        send_word(w, speck_encrypt(cur_k, cur_l, w));
      end
    end

    in_valid_i <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
